// ----- hw/rtl/ksc_pkg.sv -----
// Package with the shared types and constants of the keyword substitution cipher.
`timescale 1ns / 1ps
package ksc_pkg;

  localparam int LETTERS                 = 26;
  localparam int DEF_MAX_KEYWORD_LETTERS = 26;
  localparam int KW_WORD_WIDTH           = 60;
  localparam int KW_TOP_WIDTH            = 10;
  localparam int KW_LEN_WIDTH            = 5;
  localparam int CFG_DATA_WIDTH          = 60;
  localparam int CFG_INDEX_WIDTH         = 2;

  localparam logic [7:0] ASCII_A = 8'd65;
  localparam logic [7:0] ASCII_Z = 8'd90;

  typedef logic [4:0] letter_t;

  localparam logic [1:0] OP_BUILD  = 2'd0;
  localparam logic [1:0] OP_DECODE = 2'd1;
  localparam logic [1:0] OP_ENCODE = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_REPEAT = 2'd1;
  localparam logic [1:0] STATUS_RANGE  = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KW_LOW    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KW_MID    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KW_TOP    = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KW_LENGTH = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FILL_KW,
    S_FILL_REST,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/ksc_cfg_if.sv -----
// Configuration write channel of the keyword substitution cipher.
`timescale 1ns / 1ps
interface ksc_cfg_if import ksc_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/ksc_item_if.sv -----
// Input item channel of the keyword substitution cipher.
`timescale 1ns / 1ps
interface ksc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_in;

  modport source (output valid, output opcode, output char_in, input ready);
  modport sink (input valid, input opcode, input char_in, output ready);
endinterface

// ----- hw/rtl/ksc_result_if.sv -----
// Result channel of the keyword substitution cipher.
`timescale 1ns / 1ps
interface ksc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [1:0] status;

  modport source (output valid, output char_out, output status, input ready);
  modport sink (input valid, input char_out, input status, output ready);
endinterface

// ----- hw/rtl/keyword_substitution_cipher.sv -----
// Top level of the keyword substitution cipher with its table build sequencer.
//
//   Channel   Direction  Beat contents
//   cfg       in         index, data (keyword words and keyword length)
//   item      in         opcode, char_in
//   result    out        char_out, status
//
// Encode, decode and pass-through items go through a table lookup into the output register.
// A build checks the L keyword letters and, if sound, writes them and the rest of the alphabet
// to the tables; L is the clamped length. One letter select and compare is reused per cycle.
// Synchronous reset loads both tables with the identity alphabet and clears the keyword.
// A new item is taken only in idle, when the output register is empty or drains in that cycle;
// a build holds its result until that register is free. Configuration beats are always taken.
`timescale 1ns / 1ps
module keyword_substitution_cipher import ksc_pkg::*; #(
  parameter int MAX_KEYWORD_LETTERS = DEF_MAX_KEYWORD_LETTERS
) (
  input  logic  clk,
  input  logic  rst,
  ksc_cfg_if.sink      cfg,
  ksc_item_if.sink     item,
  ksc_result_if.source result
);

  logic [KW_WORD_WIDTH-1:0] keyword_letters_low;
  logic [KW_WORD_WIDTH-1:0] keyword_letters_mid;
  logic [KW_TOP_WIDTH-1:0]  keyword_letters_top;
  logic [KW_LEN_WIDTH-1:0]  keyword_length;

  letter_t code_table  [LETTERS];
  letter_t plain_table [LETTERS];

  state_t          state, state_next;
  letter_t         idx, idx_next;
  letter_t         n, n_next;
  logic [LETTERS-1:0] used, used_next;
  logic            range_flag, range_flag_next;
  logic            repeat_flag, repeat_flag_next;
  logic [1:0]      build_status, build_status_next;
  logic            out_valid, out_valid_next;
  logic [7:0]      out_char, out_char_next;
  logic [1:0]      out_status, out_status_next;

  logic [2*KW_WORD_WIDTH+KW_TOP_WIDTH-1:0] kw_all;
  logic [KW_LEN_WIDTH-1:0] len_eff;
  letter_t  kw_letter;
  logic     kw_in_range;
  logic     last_kw;
  logic     out_free;
  logic     item_fire;
  logic     is_upper;
  letter_t  char_idx;
  logic     tbl_we;
  letter_t  tbl_code_addr;
  letter_t  tbl_letter;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keyword_letters_low <= '0;
      keyword_letters_mid <= '0;
      keyword_letters_top <= '0;
      keyword_length      <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_KW_LOW:    keyword_letters_low <= cfg.data;
        CFG_KW_MID:    keyword_letters_mid <= cfg.data;
        CFG_KW_TOP:    keyword_letters_top <= cfg.data[KW_TOP_WIDTH-1:0];
        CFG_KW_LENGTH: keyword_length      <= cfg.data[KW_LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign kw_all = {keyword_letters_top, keyword_letters_mid, keyword_letters_low};
  assign len_eff = (keyword_length > KW_LEN_WIDTH'(MAX_KEYWORD_LETTERS)) ?
                   KW_LEN_WIDTH'(MAX_KEYWORD_LETTERS) : keyword_length;
  assign kw_letter   = kw_all[8'(idx) * 8'd5 +: 5];
  assign kw_in_range = kw_letter < letter_t'(LETTERS);
  assign last_kw     = idx == (len_eff - 5'd1);

  assign out_free  = !out_valid || result.ready;
  assign item.ready = (state == S_IDLE) && out_free;
  assign item_fire = item.valid && item.ready;
  assign is_upper  = (item.char_in >= ASCII_A) && (item.char_in <= ASCII_Z);
  assign char_idx  = 5'(item.char_in - ASCII_A);

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    n_next            = n;
    used_next         = used;
    range_flag_next   = range_flag;
    repeat_flag_next  = repeat_flag;
    build_status_next = build_status;
    out_valid_next    = out_valid && !result.ready;
    out_char_next     = out_char;
    out_status_next   = out_status;
    tbl_we            = 1'b0;
    tbl_code_addr     = n;
    tbl_letter        = kw_letter;
    case (state)
      S_IDLE: begin
        if (item_fire) begin
          if (item.opcode == OP_BUILD) begin
            idx_next         = '0;
            n_next           = '0;
            used_next        = '0;
            range_flag_next  = 1'b0;
            repeat_flag_next = 1'b0;
            state_next       = (len_eff == '0) ? S_FILL_REST : S_CHECK;
          end else begin
            out_valid_next  = 1'b1;
            out_status_next = STATUS_OK;
            out_char_next   = item.char_in;
            if (is_upper && item.opcode == OP_DECODE) begin
              out_char_next = ASCII_A + 8'(plain_table[char_idx]);
            end else if (is_upper && item.opcode == OP_ENCODE) begin
              out_char_next = ASCII_A + 8'(code_table[char_idx]);
            end
          end
        end
      end
      S_CHECK: begin
        if (!kw_in_range) begin
          range_flag_next = 1'b1;
        end else begin
          if (used[kw_letter]) begin
            repeat_flag_next = 1'b1;
          end
          used_next[kw_letter] = 1'b1;
        end
        if (last_kw) begin
          idx_next = '0;
          if (range_flag_next) begin
            build_status_next = STATUS_RANGE;
            state_next        = S_DONE;
          end else if (repeat_flag_next) begin
            build_status_next = STATUS_REPEAT;
            state_next        = S_DONE;
          end else begin
            state_next = S_FILL_KW;
          end
        end else begin
          idx_next = idx + 5'd1;
        end
      end
      S_FILL_KW: begin
        tbl_we = 1'b1;
        n_next = n + 5'd1;
        if (last_kw) begin
          idx_next   = '0;
          state_next = S_FILL_REST;
        end else begin
          idx_next = idx + 5'd1;
        end
      end
      S_FILL_REST: begin
        tbl_letter = idx;
        if (!used[idx] && n < letter_t'(LETTERS)) begin
          tbl_we = 1'b1;
          n_next = n + 5'd1;
        end
        if (idx == letter_t'(LETTERS - 1)) begin
          build_status_next = STATUS_OK;
          state_next        = S_DONE;
        end else begin
          idx_next = idx + 5'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_char_next   = '0;
          out_status_next = build_status;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      idx         <= '0;
      n           <= '0;
      used        <= '0;
      range_flag  <= 1'b0;
      repeat_flag <= 1'b0;
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      idx         <= idx_next;
      n           <= n_next;
      used        <= used_next;
      range_flag  <= range_flag_next;
      repeat_flag <= repeat_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    build_status <= build_status_next;
    out_char     <= out_char_next;
    out_status   <= out_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LETTERS; i++) begin
        code_table[i]  <= letter_t'(i);
        plain_table[i] <= letter_t'(i);
      end
    end else if (tbl_we) begin
      code_table[tbl_code_addr] <= tbl_letter;
      plain_table[tbl_letter]   <= n;
    end
  end

  assign result.valid    = out_valid;
  assign result.char_out = out_char;
  assign result.status   = out_status;

`ifndef SYNTHESIS
  a_fill_only_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL_KW || state == S_FILL_REST) |-> !range_flag && !repeat_flag)
    else $error("table fill started for a faulty keyword");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> idx < letter_t'(LETTERS))
    else $error("letter counter ran past the alphabet");

  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (n < letter_t'(LETTERS)) && (tbl_letter < letter_t'(LETTERS)))
    else $error("table write outside the alphabet");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> out_valid && state == S_IDLE)
    else $error("build result not loaded when the output register was free");

  a_fill_complete: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL_REST && idx == letter_t'(LETTERS - 1)) |=> n == letter_t'(LETTERS))
    else $error("table fill did not place every letter");
`endif

endmodule
